FILE: rtl/nsr_pkg.sv
// Package for the Newton square root block: config register codes, field widths,
// controller state type and the command/status words between controller and datapath.
// No dependencies.
`default_nettype none

package nsr_pkg;

  localparam int TOL_W     = 16;
  localparam int STEP_W    = 6;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

  localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd1000;
  localparam logic [STEP_W-1:0] LIMIT_RESET = 6'd32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_THR_START,
    ST_THR_WAIT,
    ST_MUL,
    ST_SUM,
    ST_TEST,
    ST_Q_WAIT,
    ST_UPDATE,
    ST_FINISH
  } nsr_state_t;

  typedef struct packed {
    logic load;       // take radicand, reset guess and step count
    logic thr_start;  // divide radicand by tolerance divisor
    logic thr_take;   // latch threshold from divider
    logic q_start;    // divide radicand by guess
    logic mul;        // partial products of guess squared
    logic sum;        // add partial products
    logic update;     // guess <= average, steps++
    logic finish;     // load output word
    logic conv;       // converged flag for output word
  } nsr_cmd_t;

  typedef struct packed {
    logic guess_zero;
    logic div_done;
    logic good;
    logic limit_hit;
    logic next_zero;
  } nsr_status_t;

endpackage

`default_nettype wire

FILE: rtl/newton_square_root.sv
// Newton (Heron) square root of an unsigned fixed-point radicand (Q16.16 by default).
// Input word: in_radicand on in_valid/in_ready. Output word: out_root, out_steps_taken,
// out_converged on out_valid/out_ready. Both channels move a word when valid and
// ready are high at a rising edge.
// Config: cfg_we writes cfg_wdata into register cfg_index (0: tolerance divisor,
// 1: iteration limit). Write only while no word is in flight.
// One word is worked on at a time; in_ready is high only while the block is idle.
// The serial divider runs once for the threshold and once per refinement step; each
// step also passes the split squarer (multiply and sum states), a test and an update.
// A new word is taken while the previous result still waits in the output register.
// If the receiver stalls, the finished word waits in the controller's final state
// until the output register frees up.
// Reset (rst_n low, synchronous) clears the control state and the output valid, and
// sets tolerance divisor 1000 and iteration limit 32.
// Uses nsr_pkg, nsr_ctrl, nsr_datapath, nsr_divider.
`default_nettype none

module newton_square_root #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [DATA_WIDTH-1:0]         in_radicand,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [DATA_WIDTH-1:0]              out_root,
  output logic [nsr_pkg::STEP_W-1:0]         out_steps_taken,
  output logic                               out_converged,
  input  wire logic                          cfg_we,
  input  wire logic [nsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nsr_pkg::CFG_W-1:0]     cfg_wdata
);

  import nsr_pkg::*;

  logic [TOL_W-1:0]  tol_r, tol_nxt;
  logic [STEP_W-1:0] limit_r, limit_nxt;

  nsr_cmd_t    cmd;
  nsr_status_t status;

  always_comb begin
    tol_nxt   = tol_r;
    limit_nxt = limit_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_TOL:   tol_nxt   = cfg_wdata[TOL_W-1:0];
        CFG_LIMIT: limit_nxt = cfg_wdata[STEP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r   <= TOL_RESET;
      limit_r <= LIMIT_RESET;
    end else begin
      tol_r   <= tol_nxt;
      limit_r <= limit_nxt;
    end
  end

  nsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nsr_datapath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .radicand   (in_radicand),
    .tol        (tol_r),
    .limit      (limit_r),
    .root       (out_root),
    .steps_taken(out_steps_taken),
    .converged  (out_converged)
  );

  // a taken word keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in flight");

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_steps_taken <= limit_r))
    else $error("step count beyond iteration limit");

  a_conv_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_converged) |-> (out_root != '0))
    else $error("converged with zero root");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.thr_start, cmd.q_start, cmd.mul, cmd.sum, cmd.update,
              cmd.finish}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

FILE: rtl/nsr_divider.sv
// Restoring divider, one quotient bit per cycle.
// Standalone; no package use.
`default_nettype none

module nsr_divider #(
  parameter int DIVIDEND_W = 48,
  parameter int DIVISOR_W  = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dvs_r, dvs_nxt;

  logic [DIVISOR_W:0] rem_sh;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  always_comb begin
    rem_sh = {rem_r, quo_r[DIVIDEND_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    fits   = (rem_sh >= {1'b0, dvs_r});

    count_nxt = count_r;
    done_nxt  = 1'b0;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dvs_nxt   = dvs_r;
    if (start) begin
      count_nxt = CNT_W'(DIVIDEND_W);
      rem_nxt   = '0;
      quo_nxt   = dividend;
      // divisor is held for the whole run
      dvs_nxt   = divisor;
    end else if (count_r != '0) begin
      count_nxt = count_r - 1'b1;
      done_nxt  = (count_r == CNT_W'(1));
      // remainder stays below divisor, so the low bits hold it
      rem_nxt   = fits ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_nxt   = {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/nsr_datapath.sv
// Datapath: guess, threshold, split squarer, shared divider and output word registers.
// Uses nsr_pkg and nsr_divider.
`default_nettype none

module nsr_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire nsr_pkg::nsr_cmd_t          cmd,
  output nsr_pkg::nsr_status_t            status,
  input  wire logic [DATA_WIDTH-1:0]      radicand,
  input  wire logic [nsr_pkg::TOL_W-1:0]  tol,
  input  wire logic [nsr_pkg::STEP_W-1:0] limit,
  output logic [DATA_WIDTH-1:0]           root,
  output logic [nsr_pkg::STEP_W-1:0]      steps_taken,
  output logic                            converged
);

  import nsr_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int WR  = DATA_WIDTH + FRAC_BITS;
  localparam int SQW = 2 * DATA_WIDTH;
  localparam int CW  = (SQW > WR) ? SQW : WR;
  localparam int H   = (DATA_WIDTH + 1) / 2;
  localparam int HW  = DATA_WIDTH - H;

  logic [DW-1:0]     rad_r;
  logic [DW-1:0]     guess_r;
  logic [STEP_W-1:0] steps_r;
  logic [WR-1:0]     thr_r;
  logic [2*HW-1:0]   pp_hh_r;
  logic [DW-1:0]     pp_hl_r;
  logic [2*H-1:0]    pp_ll_r;
  logic [SQW-1:0]    sq_r;
  logic [DW-1:0]     root_r;
  logic [STEP_W-1:0] steps_out_r;
  logic              conv_r;

  logic [WR-1:0] wide_rad;
  logic [DW-1:0] tol_eff;
  logic [DW-1:0] divisor;
  logic          div_done;
  logic [WR-1:0] quo;
  logic [H-1:0]  g_lo;
  logic [HW-1:0] g_hi;
  logic [CW-1:0] sq_x, rad_x, err;
  logic [WR:0]   quo_x;
  logic [DW-1:0] q_sat;
  logic [DW:0]   avg_sum;
  logic [DW-1:0] next_guess;

  always_comb begin
    wide_rad = WR'(rad_r) << FRAC_BITS;
    tol_eff  = (tol == '0) ? DW'(1) : DW'(tol);
    divisor  = cmd.q_start ? guess_r : tol_eff;
    g_lo     = guess_r[H-1:0];
    g_hi     = guess_r[DW-1:H];

    sq_x  = CW'(sq_r);
    rad_x = CW'(wide_rad);
    err   = (sq_x >= rad_x) ? (sq_x - rad_x) : (rad_x - sq_x);

    // saturate quotient to the data width
    quo_x      = {1'b0, quo};
    q_sat      = ((quo_x >> DW) != '0) ? '1 : quo[DW-1:0];
    avg_sum    = {1'b0, guess_r} + {1'b0, q_sat};
    next_guess = avg_sum[DW:1];

    status.guess_zero = (guess_r == '0);
    status.div_done   = div_done;
    status.good       = (err < CW'(thr_r));
    status.limit_hit  = (steps_r >= limit);
    status.next_zero  = (next_guess == '0);
  end

  nsr_divider #(
    .DIVIDEND_W(WR),
    .DIVISOR_W (DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.thr_start | cmd.q_start),
    .dividend(wide_rad),
    .divisor (divisor),
    .done    (div_done),
    .quotient(quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rad_r   <= radicand;
      guess_r <= DW'(1) << FRAC_BITS;
      steps_r <= '0;
    end else if (cmd.update) begin
      guess_r <= next_guess;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.thr_take) begin
      thr_r <= quo;
    end
    // square split in halves: hi^2 << 2H + 2*hi*lo << H + lo^2
    if (cmd.mul) begin
      pp_hh_r <= (2*HW)'(g_hi) * (2*HW)'(g_hi);
      pp_hl_r <= DW'(g_hi) * DW'(g_lo);
      pp_ll_r <= (2*H)'(g_lo) * (2*H)'(g_lo);
    end
    if (cmd.sum) begin
      sq_r <= (SQW'(pp_hh_r) << (2*H)) + (SQW'(pp_hl_r) << (H+1)) + SQW'(pp_ll_r);
    end
    if (cmd.finish) begin
      root_r      <= guess_r;
      steps_out_r <= steps_r;
      conv_r      <= cmd.conv;
    end
  end

  assign root        = root_r;
  assign steps_taken = steps_out_r;
  assign converged   = conv_r;

endmodule

`default_nettype wire

FILE: rtl/nsr_ctrl.sv
// Controller FSM: sequences threshold divide, square, test and Newton steps;
// owns the input ready and output valid. Uses nsr_pkg.
`default_nettype none

module nsr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire nsr_pkg::nsr_status_t status,
  output nsr_pkg::nsr_cmd_t         cmd
);

  import nsr_pkg::*;

  nsr_state_t state_r, state_nxt;
  logic       conv_r, conv_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      conv_r      <= conv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    conv_nxt      = conv_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.conv      = conv_r;
    in_ready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_THR_START;
        end
      end
      ST_THR_START: begin
        if (status.guess_zero) begin
          conv_nxt  = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          cmd.thr_start = 1'b1;
          state_nxt     = ST_THR_WAIT;
        end
      end
      ST_THR_WAIT: begin
        if (status.div_done) begin
          cmd.thr_take = 1'b1;
          state_nxt    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        if (status.good) begin
          conv_nxt  = 1'b1;
          state_nxt = ST_FINISH;
        end else if (status.limit_hit) begin
          conv_nxt  = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          cmd.q_start = 1'b1;
          state_nxt   = ST_Q_WAIT;
        end
      end
      ST_Q_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // a step that would land on zero is dropped
        if (status.next_zero) begin
          conv_nxt  = 1'b0;
          state_nxt = ST_FINISH;
        end else begin
          cmd.update = 1'b1;
          state_nxt  = ST_MUL;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Testbench for newton_square_root: directed and random radicands under several
// tolerance/limit settings and handshake idling, checked against a local predictor.
// Depends on rtl/nsr_pkg.sv and rtl/newton_square_root.sv.
`default_nettype none

module tb_top;
  import nsr_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam logic [63:0] DATA_MASK = (64'd1 << DW) - 64'd1;
  // slowest correct run: every word at 63 steps, plus stalls and gaps
  localparam int unsigned MAX_CYCLES = 25_000_000;

  typedef struct packed {
    logic [DW-1:0]     root;
    logic [STEP_W-1:0] steps;
    logic              conv;
  } root_word_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [DW-1:0]        in_radicand = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [DW-1:0]        out_root;
  logic [STEP_W-1:0]    out_steps_taken;
  logic                 out_converged;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // register copies for the predictor
  logic [TOL_W-1:0]  tol_copy = TOL_RESET;
  logic [STEP_W-1:0] limit_copy = LIMIT_RESET;

  root_word_t  pending_roots[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  newton_square_root #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_radicand    (in_radicand),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_root       (out_root),
    .out_steps_taken(out_steps_taken),
    .out_converged  (out_converged),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic root_word_t newton_root(input logic [DW-1:0] rad);
    logic [63:0] wide_rad;
    logic [63:0] thr;
    logic [63:0] guess;
    logic [63:0] sq;
    logic [63:0] err;
    logic [63:0] quot;
    logic [63:0] nxt;
    int unsigned steps;
    logic        conv;
    logic        done;
    root_word_t  w;
    wide_rad = 64'(rad) << FB;
    thr = wide_rad / ((tol_copy == '0) ? 64'd1 : 64'(tol_copy));
    guess = (64'd1 << FB) & DATA_MASK;
    steps = 0;
    conv = 1'b0;
    done = 1'b0;
    // tolerance test first, then the limit, then one Heron step
    while (!done && guess != 64'd0) begin
      sq = guess * guess;
      err = (sq >= wide_rad) ? sq - wide_rad : wide_rad - sq;
      if (err < thr) begin
        conv = 1'b1;
        done = 1'b1;
      end else if (steps >= limit_copy) begin
        done = 1'b1;
      end else begin
        quot = wide_rad / guess;
        if (quot > DATA_MASK) quot = DATA_MASK;
        nxt = ((guess + quot) >> 1) & DATA_MASK;
        if (nxt == 64'd0) begin
          done = 1'b1;
        end else begin
          guess = nxt;
          steps++;
        end
      end
    end
    w.root = guess[DW-1:0];
    w.steps = steps[STEP_W-1:0];
    w.conv = conv;
    return w;
  endfunction

  function automatic logic [DW-1:0] random_radicand();
    int unsigned pick;
    int unsigned k;
    pick = $urandom_range(99);
    k = $urandom_range(65535);
    if (pick < 6) begin
      case ($urandom_range(5))
        0: return '0;
        1: return 32'd1;
        2: return '1;
        3: return 32'h0001_0000;
        4: return 32'h8000_0000;
        default: return 32'($urandom_range(255));
      endcase
    end else if (pick < 18) begin
      return 32'(k * k);  // exact square, root k << 8
    end else begin
      return $urandom >> $urandom_range(31);
    end
  endfunction

  task automatic note_mismatch(input string msg);
    $display("tb mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic send_radicand(input logic [DW-1:0] rad);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_radicand <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_radicand <= rad;
    do @(posedge clk); while (!in_ready);
    pending_roots.push_back(newton_root(rad));
  endtask

  // drop valid and wait until every word is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == CFG_TOL) tol_copy = val[TOL_W-1:0];
    else limit_copy = val[STEP_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned idle, input int unsigned stall);
    send_idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_radicand(random_radicand());
  endtask

  task automatic test_field_extremes();
    set_idling(0, 0);
    send_radicand('0);
    send_radicand(32'd1);
    send_radicand(32'd2);
    send_radicand(32'h0000_0100);
    send_radicand(32'h0000_FFFF);
    send_radicand(32'h0001_0000);
    send_radicand(32'h0004_0000);
    send_radicand(32'h0002_0000);
    send_radicand(32'h7FFF_FFFF);
    send_radicand(32'h8000_0000);
    send_radicand(32'hFFFF_0000);
    send_radicand('1);
  endtask

  task automatic test_limit_zero();
    // upper data bits set: only the low six reach the limit
    write_reg(CFG_LIMIT, 16'hFFC0);
    send_radicand(32'h0001_0000);
    send_radicand(32'h0009_0000);
    send_radicand('0);
  endtask

  task automatic test_tolerance_zero();
    write_reg(CFG_TOL, 16'h0000);
    write_reg(CFG_LIMIT, 16'h5541);
    send_radicand(32'h0001_0000);
    send_radicand(32'h0010_0000);
    send_radicand('1);
  endtask

  task automatic test_tight_tolerance();
    write_reg(CFG_TOL, 16'hFFFF);
    write_reg(CFG_LIMIT, 16'd63);
    send_radicand(32'd1);
    send_radicand(32'd3);
    send_radicand('0);
    send_radicand('1);
    set_idling(53, 0);
    send_random(230);
  endtask

  task automatic test_defaults_random();
    write_reg(CFG_TOL, 16'd1000);
    write_reg(CFG_LIMIT, 16'd32);
    set_idling(0, 0);
    send_random(300);
  endtask

  task automatic test_loose_tolerance();
    write_reg(CFG_TOL, 16'd1);
    write_reg(CFG_LIMIT, 16'd5);
    set_idling(0, 53);
    send_random(250);
  endtask

  task automatic test_shuffled_settings();
    set_idling(20, 20);
    repeat (5) begin
      write_reg(CFG_TOL, 16'($urandom));
      write_reg(CFG_LIMIT, 16'($urandom));
      send_random(80);
    end
  endtask

  task automatic test_short_limit();
    write_reg(CFG_TOL, 16'd100);
    write_reg(CFG_LIMIT, 16'd1);
    set_idling(53, 53);
    send_random(100);
    write_reg(CFG_LIMIT, 16'd12);
    set_idling(0, 0);
    send_random(150);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : check_words
    root_word_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_roots.size() == 0) begin
        note_mismatch($sformatf("unexpected word root=%h steps=%0d conv=%b",
                                out_root, out_steps_taken, out_converged));
      end else begin
        want = pending_roots.pop_front();
        if (out_root !== want.root)
          note_mismatch($sformatf("root %h, expected %h", out_root, want.root));
        if (out_steps_taken !== want.steps)
          note_mismatch($sformatf("steps_taken %0d, expected %0d (root %h)",
                                  out_steps_taken, want.steps, want.root));
        if (out_converged !== want.conv)
          note_mismatch($sformatf("converged %b, expected %b (root %h)",
                                  out_converged, want.conv, want.root));
      end
    end
  end

  initial begin
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_limit_zero();
    test_tolerance_zero();
    test_tight_tolerance();
    test_defaults_random();
    test_loose_tolerance();
    test_shuffled_settings();
    test_short_limit();
    drain();
    repeat (200) @(posedge clk);
    if (pending_roots.size() != 0) note_mismatch("words still expected at end of run");
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
